// File: sv/tqb_pkg.sv
package tqb_pkg;

    localparam int DEPTH = 16;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW    = $clog2(DEPTH + 1);
    localparam int TW    = 32;
    localparam int CW    = 8;
    localparam int SW    = ((CW > FW) ? CW : FW) + 1;

    localparam int IN_W  = 16;
    localparam int OUT_W = 40;

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_DUMP = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OVERFLOW  = 3'd1;
    localparam logic [2:0] ST_UNDERFLOW = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_ENTRY     = 3'd4;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [TW-1:0] wdata;
        logic          re;
        logic [AW-1:0] raddr;
    } t_ram_req;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

// File: sv/ticket_queue_batch_core.sv
// Push of n: the command is accepted, min(n, free slots) slots are written, then the result word.
// Pop and dump of an empty queue: the command is accepted, then the result word.
// Dump of k entries: one read, then one word per cycle unless the output stalls, k words in all.
// One command at a time: the input stays closed until the command's last word is registered.
// Synchronous active-low reset empties the queue and clears the ticket counter;
// slot memory contents are not cleared.
module ticket_queue_batch_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [tqb_pkg::IN_W-1:0]   i_s_tdata,   // command[1:0], count[9:2], zero pad
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [tqb_pkg::OUT_W-1:0]  o_m_tdata,   // status[2:0], ticket[34:3], zero pad
    output logic                       o_m_tlast
);

    tqb_pkg::t_ram_req           ram_req;
    logic [tqb_pkg::TW-1:0]      ram_rdata;
    logic [2:0]                  status;
    logic [tqb_pkg::TW-1:0]      ticket;

    tqb_ram #(
        .W (tqb_pkg::TW),
        .D (tqb_pkg::DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    tqb_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_cmd    (i_s_tdata[1:0]),
        .i_count  (i_s_tdata[9:2]),
        .o_req    (ram_req),
        .i_rdata  (ram_rdata),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_status (status),
        .o_ticket (ticket),
        .o_last   (o_m_tlast)
    );

    assign o_m_tdata = {5'b0, ticket, status};

endmodule

// File: sv/tqb_ram.sv
module tqb_ram #(
    parameter int W = 32,
    parameter int D = 16
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                        i_wdata,
    input  logic                                i_re,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                        o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/tqb_seq.sv
module tqb_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_cmd,
    input  logic [tqb_pkg::CW-1:0]    i_count,
    output tqb_pkg::t_ram_req         o_req,
    input  logic [tqb_pkg::TW-1:0]    i_rdata,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [2:0]                o_status,
    output logic [tqb_pkg::TW-1:0]    o_ticket,
    output logic                      o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PUSH,
        S_RESP,
        S_DUMP
    } t_state;

    t_state                    r_state, n_state;
    logic [tqb_pkg::AW-1:0]    r_head, n_head;
    logic [tqb_pkg::FW-1:0]    r_fill, n_fill;
    logic [tqb_pkg::TW-1:0]    r_counter, n_counter;
    logic [tqb_pkg::AW-1:0]    r_tail, n_tail;
    logic [tqb_pkg::AW-1:0]    r_ptr, n_ptr;
    logic [tqb_pkg::FW-1:0]    r_left, n_left;
    logic [tqb_pkg::CW-1:0]    r_skip, n_skip;
    logic [2:0]                r_status, n_status;
    logic                      r_o_valid, n_o_valid;
    logic [2:0]                r_o_status, n_o_status;
    logic [tqb_pkg::TW-1:0]    r_o_ticket, n_o_ticket;
    logic                      r_o_last, n_o_last;

    logic                      accept;
    logic                      out_free;
    logic [tqb_pkg::SW-1:0]    cnt_x, fill_x, space_x, nwr, head_sum, tail_sum;
    logic                      over;
    logic [tqb_pkg::AW-1:0]    next_ptr;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;

    always_comb begin
        cnt_x    = tqb_pkg::SW'(i_count);
        fill_x   = tqb_pkg::SW'(r_fill);
        space_x  = tqb_pkg::SW'(tqb_pkg::DEPTH) - fill_x;
        over     = cnt_x > space_x;
        nwr      = over ? space_x : cnt_x;
        head_sum = tqb_pkg::SW'(r_head) + cnt_x;
        if (head_sum >= tqb_pkg::SW'(tqb_pkg::DEPTH)) begin
            head_sum = head_sum - tqb_pkg::SW'(tqb_pkg::DEPTH);
        end
        tail_sum = tqb_pkg::SW'(r_head) + fill_x;
        if (tail_sum >= tqb_pkg::SW'(tqb_pkg::DEPTH)) begin
            tail_sum = tail_sum - tqb_pkg::SW'(tqb_pkg::DEPTH);
        end
        next_ptr = tqb_pkg::ptr_inc(r_ptr);
    end

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_fill     = r_fill;
        n_counter  = r_counter;
        n_tail     = r_tail;
        n_ptr      = r_ptr;
        n_left     = r_left;
        n_skip     = r_skip;
        n_status   = r_status;
        n_o_valid  = r_o_valid && !i_ready;
        n_o_status = r_o_status;
        n_o_ticket = r_o_ticket;
        n_o_last   = r_o_last;
        o_req      = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        tqb_pkg::CMD_PUSH: begin
                            n_status = over ? tqb_pkg::ST_OVERFLOW : tqb_pkg::ST_OK;
                            if (nwr == '0) begin
                                n_counter = r_counter + tqb_pkg::TW'(i_count);
                                n_state   = S_RESP;
                            end else begin
                                n_left  = nwr[tqb_pkg::FW-1:0];
                                n_skip  = tqb_pkg::CW'(cnt_x - nwr);
                                n_tail  = tail_sum[tqb_pkg::AW-1:0];
                                n_state = S_PUSH;
                            end
                        end
                        tqb_pkg::CMD_POP: begin
                            // An oversized pop drains the queue but leaves the head alone.
                            if (cnt_x > fill_x) begin
                                n_fill   = '0;
                                n_status = tqb_pkg::ST_UNDERFLOW;
                            end else begin
                                n_head   = head_sum[tqb_pkg::AW-1:0];
                                n_fill   = tqb_pkg::FW'(fill_x - cnt_x);
                                n_status = tqb_pkg::ST_OK;
                            end
                            n_state = S_RESP;
                        end
                        tqb_pkg::CMD_DUMP: begin
                            if (r_fill == '0) begin
                                n_status = tqb_pkg::ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                o_req.re    = 1'b1;
                                o_req.raddr = r_head;
                                n_ptr       = r_head;
                                n_left      = r_fill;
                                n_state     = S_DUMP;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_PUSH: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_tail;
                o_req.wdata = r_counter + 1'b1;
                n_tail      = tqb_pkg::ptr_inc(r_tail);
                n_fill      = r_fill + 1'b1;
                n_left      = r_left - 1'b1;
                if (r_left == tqb_pkg::FW'(1)) begin
                    // Refused tickets are skipped once the last slot is written.
                    n_counter = r_counter + 1'b1 + tqb_pkg::TW'(r_skip);
                    n_state   = S_RESP;
                end else begin
                    n_counter = r_counter + 1'b1;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_ticket = '0;
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_DUMP: begin
                // Read data holds until the next read, so a stalled output loses nothing.
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = tqb_pkg::ST_ENTRY;
                    n_o_ticket = i_rdata;
                    n_o_last   = (r_left == tqb_pkg::FW'(1));
                    n_left     = r_left - 1'b1;
                    if (r_left == tqb_pkg::FW'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        o_req.re    = 1'b1;
                        o_req.raddr = next_ptr;
                        n_ptr       = next_ptr;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_fill    <= '0;
            r_counter <= '0;
            r_left    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_fill    <= n_fill;
            r_counter <= n_counter;
            r_left    <= n_left;
            r_o_valid <= n_o_valid;
        end
        r_tail     <= n_tail;
        r_ptr      <= n_ptr;
        r_skip     <= n_skip;
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_o_ticket <= n_o_ticket;
        r_o_last   <= n_o_last;
    end

    assign o_valid  = r_o_valid;
    assign o_status = r_o_status;
    assign o_ticket = r_o_ticket;
    assign o_last   = r_o_last;

endmodule

// File: sv/tqb_chk.sv
module tqb_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_s_tvalid,
    input logic                       o_s_tready,
    input logic [tqb_pkg::IN_W-1:0]   i_s_tdata,
    input logic                       o_m_tvalid,
    input logic                       i_m_tready,
    input logic [tqb_pkg::OUT_W-1:0]  o_m_tdata,
    input logic                       o_m_tlast
);

    // A held output word must not change or vanish.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output word changed while stalled");

    // Every real command keeps the input closed for at least the next cycle.
    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tdata[1:0] != 2'd3) |=> !o_s_tready)
        else $error("input accepted while a command is in progress");

    // Only dumped entries can be followed by more words of the same command.
    a_nonlast_is_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> o_m_tdata[2:0] == tqb_pkg::ST_ENTRY)
        else $error("non-final word is not a dump entry");

    // Status words carry a zero ticket.
    a_status_ticket_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[2:0] != tqb_pkg::ST_ENTRY) |-> o_m_tdata[34:3] == '0)
        else $error("status word carries a nonzero ticket");

endmodule

bind ticket_queue_batch_core tqb_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

// File: dv/ticket_queue_batch_core_tb.sv
module ticket_queue_batch_core_tb;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic [2:0]             status;
        logic [tqb_pkg::TW-1:0] ticket;
        logic                   last;
    } t_word;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [tqb_pkg::IN_W-1:0]   s_tdata = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [tqb_pkg::OUT_W-1:0]  m_tdata;
    logic                       m_tlast;

    // Shadow of the ticket queue, updated at each accepted command.
    logic [tqb_pkg::TW-1:0]     queue_slots [tqb_pkg::DEPTH];
    logic [tqb_pkg::AW-1:0]     queue_head = '0;
    logic [tqb_pkg::FW-1:0]     queue_fill = '0;
    logic [tqb_pkg::TW-1:0]     ticket_seq = '0;
    t_word                      awaited_words [$];

    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                mismatches = 0;
    int                cycle_count = 0;

    ticket_queue_batch_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),    // command[1:0], count[9:2], zero pad
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),    // status[2:0], ticket[34:3], zero pad
        .o_m_tlast  (m_tlast)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [tqb_pkg::TW-1:0] got,
                                   input logic [tqb_pkg::TW-1:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("MISMATCH %s: got %0h, expected %0h (cycle %0d)",
                     what, got, want, cycle_count);
    endtask

    function automatic void append_word(input logic [2:0] status,
                                        input logic [tqb_pkg::TW-1:0] ticket,
                                        input logic last);
        t_word w;
        w.status = status;
        w.ticket = ticket;
        w.last   = last;
        awaited_words.push_back(w);
    endfunction

    // Applies one accepted command to the shadow queue and queues the words it owes.
    function automatic void apply_ticket_command(input logic [1:0] cmd,
                                                 input logic [tqb_pkg::CW-1:0] cnt);
        logic [2:0] status;
        int         pos;
        status = tqb_pkg::ST_OK;
        case (cmd)
            tqb_pkg::CMD_PUSH: begin
                for (int i = 0; i < int'(cnt); i++) begin
                    if (int'(queue_fill) >= tqb_pkg::DEPTH) begin
                        // Refused tickets are still consumed from the sequence.
                        ticket_seq = ticket_seq + tqb_pkg::TW'(int'(cnt) - i);
                        status = tqb_pkg::ST_OVERFLOW;
                        break;
                    end
                    ticket_seq = ticket_seq + 1'b1;
                    pos = (int'(queue_head) + int'(queue_fill)) % tqb_pkg::DEPTH;
                    queue_slots[pos] = ticket_seq;
                    queue_fill = queue_fill + 1'b1;
                end
                append_word(status, '0, 1'b1);
            end
            tqb_pkg::CMD_POP: begin
                if (int'(cnt) > int'(queue_fill)) begin
                    queue_fill = '0;
                    status = tqb_pkg::ST_UNDERFLOW;
                end else begin
                    queue_head = tqb_pkg::AW'((int'(queue_head) + int'(cnt)) % tqb_pkg::DEPTH);
                    queue_fill = queue_fill - tqb_pkg::FW'(cnt);
                end
                append_word(status, '0, 1'b1);
            end
            tqb_pkg::CMD_DUMP: begin
                if (queue_fill == 0) begin
                    append_word(tqb_pkg::ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = 0; i < int'(queue_fill); i++) begin
                        pos = (int'(queue_head) + i) % tqb_pkg::DEPTH;
                        append_word(tqb_pkg::ST_ENTRY, queue_slots[pos],
                                    (i + 1 == int'(queue_fill)));
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Result side: random back-pressure and the compare against the oldest awaited word.
    always @(posedge i_clk) begin
        t_word want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (m_tvalid && m_tready) begin
                if (awaited_words.size() == 0) begin
                    report_mismatch("word with nothing awaited", {29'd0, m_tdata[2:0]}, '0);
                end else begin
                    want = awaited_words.pop_front();
                    if (m_tdata[2:0] !== want.status)
                        report_mismatch("status", {29'd0, m_tdata[2:0]}, {29'd0, want.status});
                    if (m_tdata[34:3] !== want.ticket)
                        report_mismatch("ticket", m_tdata[34:3], want.ticket);
                    if (m_tlast !== want.last)
                        report_mismatch("last", {31'd0, m_tlast}, {31'd0, want.last});
                end
            end
        end
    end

    // Called at a clock edge; returns at the edge where the word is taken.
    task automatic send_command(input logic [1:0] cmd, input logic [tqb_pkg::CW-1:0] cnt);
        int gap;
        gap = 0;
        while (gap < 60 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(tqb_pkg::IN_W - tqb_pkg::CW - 2){1'b0}}, cnt, cmd};
        do @(posedge i_clk); while (!s_tready);
        apply_ticket_command(cmd, cnt);
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (awaited_words.size() != 0);
    endtask

    task automatic test_directed();
        send_command(tqb_pkg::CMD_DUMP, 8'h00);    // dump of an empty queue
        send_command(tqb_pkg::CMD_POP, 8'd1);      // pop on empty
        send_command(tqb_pkg::CMD_PUSH, 8'd0);     // zero counts change nothing
        send_command(tqb_pkg::CMD_POP, 8'd0);
        send_command(tqb_pkg::CMD_PUSH, 8'd1);
        send_command(tqb_pkg::CMD_DUMP, 8'hFF);
        send_command(tqb_pkg::CMD_PUSH, 8'hFF);    // fills the queue, rest skipped
        send_command(tqb_pkg::CMD_DUMP, 8'd0);
        send_command(tqb_pkg::CMD_POP, 8'd16);     // exactly the fill level
        send_command(tqb_pkg::CMD_DUMP, 8'd0);
        send_command(tqb_pkg::CMD_PUSH, 8'd16);    // fills exactly
        send_command(tqb_pkg::CMD_PUSH, 8'd1);     // already full
        send_command(tqb_pkg::CMD_DUMP, 8'd1);
        send_command(tqb_pkg::CMD_POP, 8'd17);     // more than held
        send_command(tqb_pkg::CMD_PUSH, 8'd5);
        send_command(tqb_pkg::CMD_POP, 8'd3);
        send_command(tqb_pkg::CMD_PUSH, 8'd20);    // wraps around the ring, then overflows
        send_command(tqb_pkg::CMD_DUMP, 8'h55);
        send_command(tqb_pkg::CMD_POP, 8'h0F);
        send_command(tqb_pkg::CMD_DUMP, 8'hAA);
        send_command(tqb_pkg::CMD_POP, 8'hAA);
        send_command(CMD_NONE, 8'hFF);             // unused command: no word comes back
        send_command(CMD_NONE, 8'h00);
        send_command(tqb_pkg::CMD_PUSH, 8'h80);
        send_command(tqb_pkg::CMD_DUMP, 8'h7F);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
        int                     r;
        logic [1:0]             cmd;
        logic [tqb_pkg::CW-1:0] cnt;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                cmd = tqb_pkg::CMD_PUSH;
                cnt = ($urandom_range(0, 9) == 0) ? tqb_pkg::CW'($urandom_range(0, 255))
                                                  : tqb_pkg::CW'($urandom_range(1, 6));
            end else if (r < 75) begin
                cmd = tqb_pkg::CMD_POP;
                cnt = ($urandom_range(0, 9) == 0)
                    ? tqb_pkg::CW'($urandom_range(0, 255))
                    : tqb_pkg::CW'($urandom_range(0, int'(queue_fill) + 1));
            end else if (r < 96) begin
                cmd = tqb_pkg::CMD_DUMP;
                cnt = tqb_pkg::CW'($urandom_range(0, 255));
            end else begin
                cmd = CMD_NONE;
                cnt = tqb_pkg::CW'($urandom_range(0, 255));
            end
            send_command(cmd, cnt);
        end
    endtask

    task automatic test_pause_until_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 50;
        send_command(tqb_pkg::CMD_PUSH, 8'd9);
        send_command(tqb_pkg::CMD_DUMP, 8'd0);
        wait_for_drain();
        send_command(tqb_pkg::CMD_POP, 8'd4);
        send_command(tqb_pkg::CMD_DUMP, 8'd0);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_traffic(0, 0, 85);
        test_pause_until_drained();
        test_random_traffic(83, 0, 85);
        test_random_traffic(0, 83, 85);
        test_random_traffic(19, 19, 85);
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (awaited_words.size() != 0)
            report_mismatch("words never delivered", tqb_pkg::TW'(awaited_words.size()), '0);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/tqb_pkg.sv
sv/tqb_ram.sv
sv/tqb_seq.sv
sv/ticket_queue_batch_core.sv
sv/tqb_chk.sv
dv/ticket_queue_batch_core_tb.sv
